[rtl/core/bdks_pkg.sv]
// Shared types and constants for the bounded dedup key set.
`default_nettype none
package bdks_pkg;

	localparam int OPCODE_W  = 2;
	localparam int KEY_W     = 32;
	localparam int EPOCH_W   = 32;
	localparam int COUNT_F_W = 5;
	localparam int S_TDATA_W = 96;
	localparam int M_TDATA_W = 40;

	localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd2;

	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic scan_end;
	} status_t;

endpackage
`default_nettype wire

[rtl/core/bdks_datapath.sv]
// Key store, scan comparator, count and epoch registers, result register.
`default_nettype none
module bdks_datapath #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  bdks_pkg::cmd_t                 cmd,
	output bdks_pkg::status_t              status,
	input  wire [bdks_pkg::OPCODE_W-1:0]   in_opcode,
	input  wire [bdks_pkg::S_TDATA_W-1:0]  in_data,
	output logic [bdks_pkg::M_TDATA_W-1:0] out_data
);

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int KW2   = 2 * bdks_pkg::KEY_W;

	logic [KW2-1:0]                   mem_q [MAX_ENTRIES];
	logic [bdks_pkg::OPCODE_W-1:0]    op_q;
	logic [KW2-1:0]                   key_q;
	logic [bdks_pkg::EPOCH_W-1:0]     ep_arg_q;
	logic [bdks_pkg::EPOCH_W-1:0]     epoch_q;
	logic [CNT_W-1:0]                 count_q;
	logic [CNT_W-1:0]                 idx_q;
	logic [KW2-1:0]                   rd_s1;
	logic                             cmp_valid_s1;
	logic                             hit_q;
	logic [bdks_pkg::M_TDATA_W-1:0]   out_q;

	logic                             is_clear;
	logic                             is_scan;
	logic                             do_store;
	logic [CNT_W-1:0]                 count_next;
	logic [bdks_pkg::EPOCH_W-1:0]     epoch_next;
	logic [31:0]                      count_ext;
	logic                             answer;
	logic                             was_present;
	logic                             set_full;

	assign is_clear = (op_q == bdks_pkg::OP_CLEAR);
	assign is_scan  = op_q inside {bdks_pkg::OP_LOOKUP, bdks_pkg::OP_INSERT};
	assign status.scan_end = !is_scan || (idx_q >= count_q);

	assign do_store = (op_q == bdks_pkg::OP_INSERT) && !hit_q
		&& (count_q < CNT_W'(MAX_ENTRIES));

	always_comb begin
		count_next = count_q;
		if (is_clear) begin
			count_next = '0;
		end else if (do_store) begin
			count_next = count_q + CNT_W'(1);
		end
	end

	assign epoch_next  = is_clear ? ep_arg_q : epoch_q;
	assign count_ext   = 32'(count_next);
	assign was_present = is_scan && hit_q;
	assign answer      = was_present || do_store;
	assign set_full    = (count_next == CNT_W'(MAX_ENTRIES));

	// Store new key at the fill position; read one entry per scan step.
	always_ff @(posedge clk) begin
		if (cmd.commit && do_store) begin
			mem_q[count_q[IDX_W-1:0]] <= key_q;
		end
		if (cmd.step) begin
			rd_s1 <= mem_q[idx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= in_opcode;
			key_q    <= {in_data[63:32], in_data[31:0]};
			ep_arg_q <= in_data[95:64];
		end
		if (cmd.commit) begin
			out_q <= {epoch_next, count_ext[bdks_pkg::COUNT_F_W-1:0], set_full,
				was_present, answer};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			epoch_q      <= '0;
			idx_q        <= '0;
			cmp_valid_s1 <= 1'b0;
			hit_q        <= 1'b0;
		end else begin
			cmp_valid_s1 <= cmd.step;
			if (cmd.load) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end else begin
				if (cmd.step) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (cmp_valid_s1 && (rd_s1 == key_q)) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				count_q <= count_next;
				epoch_q <= epoch_next;
			end
		end
	end

	assign out_data = out_q;

endmodule
`default_nettype wire

[rtl/core/bdks_ctrl.sv]
// Sequencer: accept, scan stored keys, commit result to the output register.
`default_nettype none
module bdks_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  wire                m_tready,
	input  bdks_pkg::status_t  status,
	output bdks_pkg::cmd_t     cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_next;
	logic       m_tvalid_q;

	assign s_tready   = (state_q == ST_IDLE);
	assign cmd.load   = s_tvalid && (state_q == ST_IDLE);
	assign cmd.step   = (state_q == ST_SCAN) && !status.scan_end;
	assign cmd.commit = (state_q == ST_COMMIT) && (!m_tvalid_q || m_tready);
	assign m_tvalid   = m_tvalid_q;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_next = ST_SCAN;
			end
			// last compare lands in the cycle that sees scan_end
			ST_SCAN: begin
				if (status.scan_end) state_next = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (cmd.commit) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.commit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/core/bounded_dedup_key_set.sv]
// Top level of the bounded dedup key set.
//
//  channel | dir | transaction contents
//  s_*     | in  | tuser: opcode; tdata: key_high, key_low, epoch_value
//  m_*     | out | tdata: answer, was_present, set_full, entry_count, current_epoch
//
// A transaction is accepted, then scans the N stored keys for lookup and insert
// (none for clear) with the single comparator walking the key memory one entry
// per cycle, then commits its result; one item is in work at a time.
// Reset empties the set and zeroes the epoch; key memory needs no clearing.
// A result waits in the output register while m_tready is low; the next
// transaction is accepted meanwhile and holds at commit until the register frees.
`default_nettype none
module bounded_dedup_key_set #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_tvalid,
	output logic                           s_tready,
	input  wire [bdks_pkg::S_TDATA_W-1:0]  s_tdata,  // key_high, key_low, epoch_value
	input  wire [bdks_pkg::OPCODE_W-1:0]   s_tuser,  // opcode
	output logic                           m_tvalid,
	input  wire                            m_tready,
	// answer, was_present, set_full, entry_count, current_epoch
	output logic [bdks_pkg::M_TDATA_W-1:0] m_tdata
);

	bdks_pkg::cmd_t    cmd;
	bdks_pkg::status_t status;

	bdks_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	bdks_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_opcode (s_tuser),
		.in_data   (s_tdata),
		.out_data  (m_tdata)
	);

endmodule
`default_nettype wire
